>>> sv/kmhid_pkg.sv
// shared types and constants for the key-matrix hid report builder
package kmhid_pkg;

  localparam int KM_ROWS     = 4;
  localparam int KM_COLUMNS  = 14;
  localparam int KM_MAX_KEYS = 6;

  localparam int NUM_SLOTS = 6;
  localparam int USAGE_W   = 8;
  localparam int MOD_W     = 8;
  localparam int COUNT_W   = 3;
  localparam int LIN_W     = 7;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [2:0]         key_row;
    logic [3:0]         key_column;
    logic [USAGE_W-1:0] usage_code;
    logic               is_pressed;
    logic [MOD_W-1:0]   modifier_bits;
    logic               skip_key;
  } in_item_t;

  typedef struct packed {
    logic [MOD_W-1:0]   report_modifiers;
    logic [COUNT_W-1:0] report_count;
    logic [USAGE_W-1:0] slot0;
    logic [USAGE_W-1:0] slot1;
    logic [USAGE_W-1:0] slot2;
    logic [USAGE_W-1:0] slot3;
    logic [USAGE_W-1:0] slot4;
    logic [USAGE_W-1:0] slot5;
  } out_item_t;

  typedef struct packed {
    logic key_write;
    logic suspend;
    logic resume;
    logic scan_rd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic evt_ok;
    logic addr_last;
  } dp_stat_t;

endpackage

>>> sv/kmhid_ctrl.sv
// controller state machine: accepts transactions, sequences the table scan
module kmhid_ctrl import kmhid_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  op_t      in_op,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_KEY: begin
              if (stat.evt_ok) begin
                cmd.key_write = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            OP_SUSPEND: cmd.suspend = 1'b1;
            OP_RESUME:  cmd.resume  = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.addr_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/kmhid_dp.sv
// datapath: usage table memory, modifier and suspend state, scan and report registers
module kmhid_dp import kmhid_pkg::*; #(
  parameter int ROWS     = KM_ROWS,
  parameter int COLUMNS  = KM_COLUMNS,
  parameter int MAX_KEYS = KM_MAX_KEYS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [USAGE_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic               susp_r;
  logic [MOD_W-1:0]   held_mod_r;

  logic [AW-1:0]      scan_addr_r;
  logic               rd_pend_r;
  logic [USAGE_W-1:0] rd_data_r;
  logic               valid_q_r;
  logic [COUNT_W-1:0] count_r;
  logic [USAGE_W-1:0] slot_r [NUM_SLOTS];
  out_item_t          out_data_r;

  logic [LIN_W-1:0]   evt_lin;
  logic [AW-1:0]      evt_addr;
  logic               row_ok, col_ok;
  logic [USAGE_W-1:0] entry;
  logic               take;
  logic [USAGE_W-1:0] wr_val;

  // row-major linear address of the event cell
  assign evt_lin  = LIN_W'(in_data.key_row) * LIN_W'(COLUMNS) + LIN_W'(in_data.key_column);
  assign evt_addr = evt_lin[AW-1:0];
  assign row_ok   = {1'b0, in_data.key_row} < 4'(ROWS);
  assign col_ok   = {1'b0, in_data.key_column} < 5'(COLUMNS);
  assign wr_val   = in_data.is_pressed ? in_data.usage_code : '0;

  assign stat.evt_ok    = row_ok && col_ok && !in_data.skip_key && !susp_r;
  assign stat.addr_last = (scan_addr_r == AW'(DEPTH - 1));

  // a cell never written since reset or suspend reads as empty
  assign entry = valid_q_r ? rd_data_r : '0;
  assign take  = rd_pend_r && (entry != '0) && (count_r < COUNT_W'(MAX_KEYS));

  always_ff @(posedge clk) begin
    if (cmd.key_write && (in_data.usage_code != '0)) mem_r[evt_addr] <= wr_val;
    if (cmd.scan_rd) begin
      rd_data_r <= mem_r[scan_addr_r];
      valid_q_r <= valid_r[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      susp_r      <= 1'b0;
      held_mod_r  <= '0;
      scan_addr_r <= '0;
      rd_pend_r   <= 1'b0;
      count_r     <= '0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
      if (cmd.suspend) begin
        valid_r    <= '0;
        held_mod_r <= '0;
        susp_r     <= 1'b1;
      end
      if (cmd.resume) susp_r <= 1'b0;
      if (cmd.key_write) begin
        held_mod_r  <= in_data.modifier_bits;
        scan_addr_r <= '0;
        count_r     <= '0;
        if (in_data.usage_code != '0) valid_r[evt_addr] <= 1'b1;
      end
      if (cmd.scan_rd && !stat.addr_last) scan_addr_r <= scan_addr_r + 1'b1;
      if (take) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_write) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_r[i] <= '0;
    end else if (take) begin
      slot_r[count_r] <= entry;
    end
    if (cmd.load_out) begin
      out_data_r.report_modifiers <= held_mod_r;
      out_data_r.report_count     <= count_r;
      out_data_r.slot0            <= slot_r[0];
      out_data_r.slot1            <= slot_r[1];
      out_data_r.slot2            <= slot_r[2];
      out_data_r.slot3            <= slot_r[3];
      out_data_r.slot4            <= slot_r[4];
      out_data_r.slot5            <= slot_r[5];
    end
  end

  assign out_data = out_data_r;

endmodule

>>> sv/key_matrix_hid_report_builder.sv
// top level of the key-matrix hid report builder
// usage:
//   in_valid/in_stall/in_data carry one operation per transaction: a key event,
//   suspend or resume. a key event in range, not a skipped key and not arriving
//   while suspended updates the held modifiers and its table cell, then yields one
//   report on out_valid/out_stall/out_data. all other transactions yield no report.
//   a report is valid after its key event is accepted and the usage table memory
//   (one read port) is scanned one cell per cycle, then a drain state for the
//   last read and an emit state for the output load. a key event holds off new
//   transactions until its report is loaded, and the load waits while the
//   previous report still sits stalled in the output register;
//   suspend, resume and dropped events are taken in the idle state, with no scan.
//   the output register parts the two sides: a new transaction is taken while
//   an earlier report waits; a stalled report holds its value.
//   reset (rst_n low, synchronous) empties the table through per-cell valid
//   bits, clears the modifiers and the suspended flag; no clearing pass needed.
module key_matrix_hid_report_builder import kmhid_pkg::*; #(
  parameter int ROWS     = KM_ROWS,
  parameter int COLUMNS  = KM_COLUMNS,
  parameter int MAX_KEYS = KM_MAX_KEYS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: accept, scan, drain, emit
  kmhid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table, modifiers, suspend flag and report assembly
  kmhid_dp #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // report never lists more keys than the limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.report_count <= COUNT_W'(MAX_KEYS)))
    else $error("report count above key limit");

  // unfilled trailing slot stays zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.report_count != 3'd6)) |-> (out_data.slot5 == 8'd0))
    else $error("slot beyond count not zero");

  // a fresh report only appears while the block is busy with a key event
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report raised while idle");

endmodule

>>> tb/sv/key_matrix_hid_report_builder_test.sv
// self-checking testbench for the key-matrix hid report builder
`timescale 1ns / 100ps

module key_matrix_hid_report_builder_test;
  import kmhid_pkg::*;

  // operation code that the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int TABLE_DEPTH   = KM_ROWS * KM_COLUMNS;
  localparam int RANDOM_EVENTS = 1150;
  localparam int LONG_HOLD     = 700;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 600000;

  // one queued transaction plus the idle cycles that follow it and whether the
  // sender must wait for every outstanding report before offering it
  typedef struct packed {
    in_item_t   ev;
    logic [2:0] gap;
    logic       drain_first;
  } pending_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pending_t  pending_events[$];
  out_item_t expected_reports[$];

  // predicted block state
  logic [USAGE_W-1:0] key_table [TABLE_DEPTH] = '{default: '0};
  logic [MOD_W-1:0]   held_mods    = '0;
  logic               is_suspended = 1'b0;

  // stimulus shaping
  int unsigned gen_idle_max = 5;
  bit          gen_drain    = 1'b0;
  int          pressed_pos[$];

  int unsigned cycles       = 0;
  int unsigned errors       = 0;
  int unsigned reports_seen = 0;
  logic [2:0]  gap_left     = '0;
  int unsigned wait_left    = 0;
  int unsigned hold_left    = 0;

  key_matrix_hid_report_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // report prediction
  // ---------------------------------------------------------------------------

  // applies one accepted transaction to the predicted state and, for a key
  // event that gets through, queues the report it produces
  function automatic void predict_report(in_item_t ev);
    out_item_t          rep;
    logic [USAGE_W-1:0] slots [NUM_SLOTS];
    int                 found;
    int                 pos;
    found = 0;
    case (ev.operation)
      OP_SUSPEND: begin
        // suspend empties the table and modifiers, even when already suspended
        is_suspended = 1'b1;
        held_mods    = '0;
        foreach (key_table[i]) key_table[i] = '0;
      end
      OP_RESUME: is_suspended = 1'b0;
      OP_KEY: begin
        if (int'(ev.key_row) < KM_ROWS && int'(ev.key_column) < KM_COLUMNS &&
            !is_suspended && !ev.skip_key) begin
          held_mods = ev.modifier_bits;
          pos = int'(ev.key_row) * KM_COLUMNS + int'(ev.key_column);
          // a zero usage leaves the cell alone, press or release
          if (ev.usage_code != '0)
            key_table[pos] = ev.is_pressed ? ev.usage_code : '0;
          foreach (slots[k]) slots[k] = '0;
          // row-major scan, first six nonzero usages win
          foreach (key_table[i]) begin
            if (key_table[i] != '0 && found < KM_MAX_KEYS) begin
              slots[found] = key_table[i];
              found++;
            end
          end
          rep.report_modifiers = held_mods;
          rep.report_count     = COUNT_W'(found);
          rep.slot0 = slots[0];
          rep.slot1 = slots[1];
          rep.slot2 = slots[2];
          rep.slot3 = slots[3];
          rep.slot4 = slots[4];
          rep.slot5 = slots[5];
          expected_reports.push_back(rep);
        end
      end
      default: ; // unused code, nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      note_mismatch("report arrived with none expected");
      return;
    end
    want = expected_reports.pop_front();
    check_field("report_modifiers", got.report_modifiers, want.report_modifiers);
    check_field("report_count", 8'(got.report_count), 8'(want.report_count));
    check_field("slot0", got.slot0, want.slot0);
    check_field("slot1", got.slot1, want.slot1);
    check_field("slot2", got.slot2, want.slot2);
    check_field("slot3", got.slot3, want.slot3);
    check_field("slot4", got.slot4, want.slot4);
    check_field("slot5", got.slot5, want.slot5);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one transaction per queue entry, idle cycles after each
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_events
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= '0;
    end else if (in_valid && in_stall) begin
      // stalled transaction stays on the port unchanged
    end else begin
      // a transaction offered and not stalled is taken at this edge
      if (in_valid)
        predict_report(in_data);
      if (gap_left != '0) begin
        gap_left <= gap_left - 3'd1;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0 &&
                   !(pending_events[0].drain_first && expected_reports.size() != 0)) begin
        nxt = pending_events.pop_front();
        in_data  <= nxt.ev;
        in_valid <= 1'b1;
        gap_left <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: short random stalls per report, two long hold-offs
  // ---------------------------------------------------------------------------

  // report taken at this edge that starts a long hold-off
  function automatic bit hold_due();
    return out_valid && !out_stall && (reports_seen == 40 || reports_seen == 800);
  endfunction

  // long hold-off: the sender keeps offering so the block backs up
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_due()) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : watch_reports
    int unsigned nxt_wait;
    int unsigned rx_max;
    if (!rst_n) begin
      out_stall <= 1'b0;
      wait_left <= 0;
    end else begin
      nxt_wait = wait_left;
      // every third stretch of reports is taken with no stalls at all
      rx_max = ((reports_seen / 120) % 3 == 2) ? 0 : 5;
      if (out_valid && !out_stall) begin
        check_report(out_data);
        reports_seen <= reports_seen + 1;
        nxt_wait = $urandom_range(0, rx_max);
      end else if (out_valid && wait_left != 0) begin
        // stall cycles only count down while a report is waiting
        nxt_wait = wait_left - 1;
      end
      wait_left <= nxt_wait;
      out_stall <= (nxt_wait != 0) || hold_due() || (hold_left > 1);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_entry(in_item_t ev);
    pending_t e;
    e.ev          = ev;
    e.gap         = 3'($urandom_range(0, gen_idle_max));
    e.drain_first = gen_drain;
    gen_drain     = 1'b0;
    pending_events.push_back(e);
  endtask

  task automatic add_key(int row, int col, int usage, bit pressed, int mods, bit skip);
    in_item_t ev;
    ev.operation     = OP_KEY;
    ev.key_row       = 3'(row);
    ev.key_column    = 4'(col);
    ev.usage_code    = 8'(usage);
    ev.is_pressed    = pressed;
    ev.modifier_bits = 8'(mods);
    ev.skip_key      = skip;
    push_entry(ev);
  endtask

  // non-key operation with random leftover fields
  task automatic add_op(logic [1:0] code);
    in_item_t ev;
    ev           = in_item_t'($urandom);
    ev.operation = op_t'(code);
    push_entry(ev);
  endtask

  // well-formed key event: presses that build up the table and releases
  // aimed at cells that were pressed earlier
  task automatic add_typing_event();
    int pick;
    int pos;
    int usage;
    int release_pct;
    release_pct = (pressed_pos.size() > 10) ? 80 : 45;
    if (pressed_pos.size() != 0 && $urandom_range(0, 99) < release_pct) begin
      pick  = $urandom_range(0, pressed_pos.size() - 1);
      pos   = pressed_pos[pick];
      usage = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
      if (usage != 0)
        pressed_pos.delete(pick);
      add_key(pos / KM_COLUMNS, pos % KM_COLUMNS, usage, 1'b0, $urandom_range(0, 255), 1'b0);
    end else begin
      pos   = $urandom_range(0, TABLE_DEPTH - 1);
      usage = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
      if (usage != 0)
        pressed_pos.push_back(pos);
      add_key(pos / KM_COLUMNS, pos % KM_COLUMNS, usage, 1'b1, $urandom_range(0, 255), 1'b0);
    end
  endtask

  // event the block must drop: out of range or a skipped key
  task automatic add_dropped_key();
    int  row;
    int  col;
    bit  skip;
    row  = $urandom_range(0, 7);
    col  = $urandom_range(0, 15);
    skip = 1'($urandom_range(0, 1));
    if (row < KM_ROWS && col < KM_COLUMNS && !skip)
      skip = 1'b1;
    add_key(row, col, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
            $urandom_range(0, 255), skip);
  endtask

  initial begin : stimulus
    int unsigned typed;
    int unsigned sel;
    int unsigned n;

    // directed: field extremes, row-major order, more than six keys held
    add_key(0, 0, 8'hFF, 1'b1, 8'hFF, 1'b0);
    add_key(KM_ROWS - 1, KM_COLUMNS - 1, 8'h01, 1'b1, 8'h00, 1'b0);
    add_key(0, 0, 8'h00, 1'b0, 8'h5A, 1'b0);      // release with zero usage
    add_key(1, 2, 8'h00, 1'b1, 8'hA5, 1'b0);      // press with zero usage
    add_key(4, 0, 8'h11, 1'b1, 8'h01, 1'b0);      // row out of range
    add_key(7, 15, 8'h22, 1'b1, 8'h02, 1'b0);
    add_key(0, 14, 8'h33, 1'b1, 8'h04, 1'b0);     // column out of range
    add_key(2, 15, 8'h34, 1'b0, 8'h08, 1'b0);
    add_key(2, 5, 8'h44, 1'b1, 8'h10, 1'b1);      // skipped key
    add_key(1, 0, 8'h80, 1'b1, 8'h20, 1'b0);
    add_key(1, 1, 8'h7F, 1'b1, 8'h40, 1'b0);
    add_key(1, 2, 8'h55, 1'b1, 8'h80, 1'b0);
    add_key(1, 3, 8'hAA, 1'b1, 8'h03, 1'b0);
    add_key(1, 4, 8'h04, 1'b1, 8'hC0, 1'b0);
    add_key(2, 6, 8'h10, 1'b1, 8'h00, 1'b0);      // beyond six keys
    add_key(0, 0, 8'hFF, 1'b0, 8'h0F, 1'b0);      // release clears the cell
    add_key(KM_ROWS - 1, KM_COLUMNS - 1, 8'h99, 1'b0, 8'hF0, 1'b0);
    add_op(OP_UNUSED);
    add_op(OP_SUSPEND);
    add_key(0, 1, 8'h20, 1'b1, 8'h11, 1'b0);      // dropped while suspended
    add_op(OP_SUSPEND);                           // suspend twice
    add_op(OP_RESUME);
    add_key(0, 1, 8'h20, 1'b1, 8'h0F, 1'b0);
    add_op(OP_RESUME);
    add_key(1, 1, 8'h21, 1'b0, 8'h00, 1'b0);

    // random part: the sender first waits for every outstanding report
    gen_drain = 1'b1;
    typed = 0;
    n     = 0;
    while (typed < RANDOM_EVENTS) begin
      // stretches of back-to-back transactions between idling stretches
      gen_idle_max = ((n / 150) % 3 == 1) ? 0 : 5;
      if (n % 400 == 399)
        gen_drain = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        // suspend, up to two events that must be dropped, then resume
        add_op(OP_SUSPEND);
        pressed_pos.delete();
        repeat ($urandom_range(0, 2)) add_typing_event();
        add_op(OP_RESUME);
      end else if (sel < 5) begin
        add_op(OP_RESUME);
      end else if (sel < 6) begin
        add_op(OP_UNUSED);
      end else if (sel < 13) begin
        add_dropped_key();
      end else begin
        add_typing_event();
        typed++;
      end
      n++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last transaction and its report, then let the block settle
    while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0 && expected_reports.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
